// ===== rtl/ssort_pkg.sv =====
// Shared types and constants of the selection sort engine.
package ssort_pkg;

    // Width of one element and of one stream word
    localparam int DATA_W        = 32;
    // Default number of buffer entries
    localparam int DEPTH_DEFAULT = 16;
    // Width of the configuration byte address
    localparam int CFG_AW        = 3;
    // Configuration register index, taken from the word address bit
    localparam logic REG_DESCENDING = 1'b0;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_OUTER,
        ST_FIRST,
        ST_SCAN,
        ST_SWAP_BEST,
        ST_SWAP_OUTER,
        ST_EMIT_RD,
        ST_EMIT_CAP
    } t_state;

endpackage

// ===== rtl/ssort_store.sv =====
// Element buffer: one write port and one read port with registered read data.
module ssort_store
    import ssort_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry into the registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ssort_ctrl.sv =====
// Sequencer of the sort engine: loads the run, sorts it in the buffer, emits it.
module ssort_ctrl
    import ssort_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_desc,
    // input stream
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_in_data,
    input  logic                     i_in_last,
    // output stream
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_out_data,
    output logic                     o_out_last,
    // buffer port
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic signed [DATA_W-1:0] o_wdata,
    output logic [AW-1:0]            o_raddr,
    input  logic signed [DATA_W-1:0] i_rdata
);

    localparam int CW = AW + 1;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_outer, n_outer;
    logic [AW-1:0]            r_scan, n_scan;
    logic [AW-1:0]            r_best, n_best;
    logic [AW-1:0]            r_pos, n_pos;
    logic [AW-1:0]            r_k, n_k;
    logic signed [DATA_W-1:0] r_best_val, n_best_val;
    logic signed [DATA_W-1:0] r_outer_val, n_outer_val;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic                     r_out_last, n_out_last;

    logic          w_in_fire;
    logic          w_close;
    logic          w_out_free;
    logic          w_better;
    logic [CW-1:0] w_n_minus1;
    logic          w_pos_end;
    logic          w_k_end;
    logic          w_sort_done;

    // Status of the current run and scan
    assign w_in_fire   = i_in_valid && (r_state == ST_LOAD);
    assign w_close     = i_in_last || (r_count == CW'(DEPTH - 1));
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_better    = i_desc ? (i_rdata > r_best_val) : (i_rdata < r_best_val);
    assign w_n_minus1  = r_count - CW'(1);
    assign w_pos_end   = ({1'b0, r_pos} == w_n_minus1);
    assign w_k_end     = ({1'b0, r_k} == w_n_minus1);
    assign w_sort_done = (({1'b0, r_outer} + CW'(2)) >= r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_fire && w_close) begin
                    n_state = (r_count == '0) ? ST_EMIT_RD : ST_OUTER;
                end
            end
            ST_OUTER:      n_state = ST_FIRST;
            ST_FIRST:      n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_pos_end) begin
                    n_state = ST_SWAP_BEST;
                end
            end
            ST_SWAP_BEST:  n_state = ST_SWAP_OUTER;
            ST_SWAP_OUTER: n_state = w_sort_done ? ST_EMIT_RD : ST_OUTER;
            ST_EMIT_RD: begin
                if (w_out_free) begin
                    n_state = ST_EMIT_CAP;
                end
            end
            ST_EMIT_CAP:   n_state = w_k_end ? ST_LOAD : ST_EMIT_RD;
            default:       n_state = ST_LOAD;
        endcase
    end

    // Datapath, buffer accesses and output word
    always_comb begin
        n_count     = r_count;
        n_outer     = r_outer;
        n_scan      = r_scan;
        n_best      = r_best;
        n_pos       = r_pos;
        n_k         = r_k;
        n_best_val  = r_best_val;
        n_outer_val = r_outer_val;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_we        = 1'b0;
        o_waddr     = r_count[AW-1:0];
        o_wdata     = i_in_data;
        o_raddr     = r_scan;
        case (r_state)
            ST_LOAD: begin
                // store the word at the end of the run
                if (w_in_fire) begin
                    o_we    = 1'b1;
                    n_count = r_count + CW'(1);
                    n_outer = '0;
                    n_k     = '0;
                end
            end
            ST_OUTER: begin
                // fetch the entry at the outer position
                o_raddr = r_outer;
                n_scan  = r_outer + AW'(1);
                n_best  = r_outer;
            end
            ST_FIRST: begin
                n_best_val  = i_rdata;
                n_outer_val = i_rdata;
                o_raddr     = r_scan;
                n_pos       = r_scan;
                n_scan      = r_scan + AW'(1);
            end
            ST_SCAN: begin
                // compare the arriving entry, keep the first extreme on ties
                if (w_better) begin
                    n_best_val = i_rdata;
                    n_best     = r_pos;
                end
                if (!w_pos_end) begin
                    o_raddr = r_scan;
                    n_pos   = r_scan;
                    n_scan  = r_scan + AW'(1);
                end
            end
            ST_SWAP_BEST: begin
                o_we    = 1'b1;
                o_waddr = r_best;
                o_wdata = r_outer_val;
            end
            ST_SWAP_OUTER: begin
                o_we    = 1'b1;
                o_waddr = r_outer;
                o_wdata = r_best_val;
                n_outer = r_outer + AW'(1);
            end
            ST_EMIT_RD: begin
                o_raddr = r_k;
            end
            ST_EMIT_CAP: begin
                // load the output word, close the run after the final one
                n_out_valid = 1'b1;
                n_out_data  = i_rdata;
                n_out_last  = w_k_end;
                if (w_k_end) begin
                    n_count = '0;
                    n_k     = '0;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_outer     <= '0;
            r_scan      <= '0;
            r_best      <= '0;
            r_pos       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_outer     <= n_outer;
            r_scan      <= n_scan;
            r_best      <= n_best;
            r_pos       <= n_pos;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_best_val  <= n_best_val;
        r_outer_val <= n_outer_val;
        r_out_data  <= n_out_data;
        r_out_last  <= n_out_last;
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_count < CW'(DEPTH)))
        else $error("run length reached the buffer depth while loading");

    a_best_not_before_outer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_best >= r_outer) && (r_best <= r_pos)))
        else $error("best position left the scanned range");

    a_slot_free_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_CAP) |-> !r_out_valid)
        else $error("output word overwritten before it was taken");

    a_run_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT_CAP) && w_k_end) |=> ((r_state == ST_LOAD) && (r_count == '0)))
        else $error("run not closed after the final word");
`endif

endmodule

// ===== rtl/selection_sort_engine_top.sv =====
// Top level of the selection sort engine: configuration port, buffer and sequencer.
//
// Usage: a run of signed 32-bit words enters on the s_ stream, one word per
// accepted transfer; s_tlast closes the run, and so does the word that fills
// the DEPTH-entry buffer. The sorted run leaves on the m_ stream with m_tlast
// on its final word. Bit 0 of the register at byte address 0 selects the
// order: 0 smallest first, 1 largest first. Write it only while the block idles.
// Loading writes each accepted word straight into the buffer. For a run of n
// words the sort then takes each outer position i from 0 to n-2 in turn: it
// fetches the entry at i, compares it with every later entry of the run and
// swaps the extreme into place with two writes, all bound by the single read
// port of the buffer. Emission reads each word from the buffer and then loads
// it into the output register. s_tready is high only while a run
// is being loaded; loading of the next run may start while the final sorted
// word still waits in the output register. When the receiver stalls,
// m_tvalid and the word hold and the sequencer waits at the next buffer read.
// Reset (synchronous, active low) empties the run, drops any pending output
// and clears the order bit; the buffer itself needs no clearing.
module selection_sort_engine_top
    import ssort_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_AW-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // input stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                     s_tlast,   // last_in
    // output stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                     m_tlast    // last_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                     r_desc;
    logic                     w_cfg_wr;
    logic                     w_sel_desc;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic [AW-1:0]            w_raddr;
    logic signed [DATA_W-1:0] w_rdata;

    // Decode the register word
    assign pready     = 1'b1;
    assign w_sel_desc = (paddr[2] == REG_DESCENDING);
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // Hold the order bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (w_cfg_wr && w_sel_desc) begin
            r_desc <= pwdata[0];
        end
    end

    // Return the register value
    always_comb begin
        prdata = '0;
        if (psel && w_sel_desc) begin
            prdata = {31'b0, r_desc};
        end
    end

    ssort_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ssort_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (r_desc),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .i_in_data   (s_tdata),
        .i_in_last   (s_tlast),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (m_tdata),
        .o_out_last  (m_tlast),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the selection sort engine: directed table, then random runs.
module tb;
    import ssort_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_MAX   = DEPTH_DEFAULT;
    localparam int CYCLE_CAP = 300000;
    localparam int DRAIN_CAP = 20000;
    localparam int SEG_WORDS = 67;
    localparam logic [CFG_AW-1:0] ADDR_ORDER = {REG_DESCENDING, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_SPARE = {~REG_DESCENDING, 2'b00};

    // One word of a sorted run as it should leave the block
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_sorted_word;

    // One row of stimulus; pinned rows carry their result typed in
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        bit                       pinned;
        logic signed [DATA_W-1:0] pin_value;
        logic                     pin_last;
    } t_stim_row;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [CFG_AW-1:0]        paddr    = '0;
    logic [31:0]              pwdata   = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic signed [DATA_W-1:0] s_tdata  = '0;   // [31:0] value
    logic                     s_tlast  = 1'b0; // last_in
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic signed [DATA_W-1:0] m_tdata;         // [31:0] sorted_value
    logic                     m_tlast;         // last_out

    // Predictor state
    logic signed [DATA_W-1:0] open_run[$];
    t_sorted_word             run_sorted[$];
    t_sorted_word             sorted_due[$];
    logic                     order_desc = 1'b0;

    int  feed_idle = 0;
    int  sink_idle = 0;
    int  cycles    = 0;
    bit  failed    = 1'b0;

    t_stim_row directed_rows[25];

    selection_sort_engine_top #(.DEPTH(DEPTH_DEFAULT)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Add one word to the open run; on the closing word sort it into run_sorted
    function automatic void absorb_word(input logic signed [DATA_W-1:0] v, input logic l);
        logic signed [DATA_W-1:0] pool [RUN_MAX];
        logic signed [DATA_W-1:0] swap_tmp;
        t_sorted_word             w;
        int                       n;
        int                       best;
        run_sorted = {};
        open_run.push_back(v);
        if (!l && open_run.size() < RUN_MAX)
            return;
        n = open_run.size();
        for (int k = 0; k < n; k++)
            pool[k] = open_run[k];
        for (int i = 0; i + 1 < n; i++) begin
            best = i;
            for (int j = i + 1; j < n; j++) begin
                if (order_desc ? (pool[j] > pool[best]) : (pool[j] < pool[best]))
                    best = j;
            end
            swap_tmp   = pool[best];
            pool[best] = pool[i];
            pool[i]    = swap_tmp;
        end
        for (int k = 0; k < n; k++) begin
            w.value = pool[k];
            w.last  = (k == n - 1);
            run_sorted.push_back(w);
        end
        open_run = {};
    endfunction

    // Drive one word, hold it until taken, then queue what it yields
    task automatic send_row(input t_stim_row row);
        t_sorted_word w;
        if ($urandom_range(99) < feed_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < feed_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.value;
        s_tlast  <= row.last;
        do @(posedge i_clk); while (!s_tready);
        absorb_word(row.value, row.last);
        if (row.pinned) begin
            w.value = row.pin_value;
            w.last  = row.pin_last;
            sorted_due.push_back(w);
        end else begin
            foreach (run_sorted[k])
                sorted_due.push_back(run_sorted[k]);
        end
    endtask

    // Register write: setup cycle, access cycle, one bus idle cycle
    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[CFG_AW-1:2] == REG_DESCENDING)
            order_desc = data[0];
        @(posedge i_clk);
    endtask

    // Read the order register back and compare
    task automatic cfg_check();
        logic [31:0] want;
        want    = {31'd0, order_desc};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ORDER;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("descending: expected %0h, actual %0h", want, prdata);
            failed = 1'b1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop the stream and wait until every sorted word has left the block
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: pick_value = $signed($urandom_range(7)) - 3;
            1: case ($urandom_range(3))
                   0: pick_value = 32'sh7FFF_FFFF;
                   1: pick_value = 32'sh8000_0000;
                   2: pick_value = -32'sd1;
                   default: pick_value = 32'sd0;
               endcase
            default: pick_value = $signed($urandom);
        endcase
    endfunction

    // Well-formed runs of random length and content; runs of RUN_MAX words fill the buffer
    task automatic random_runs(input int quota);
        t_stim_row row;
        int        sent;
        int        len;
        int        pick;
        sent       = 0;
        row.pinned = 1'b0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 60)
                len = $urandom_range(5, 1);
            else if (pick < 85)
                len = $urandom_range(RUN_MAX - 1, 6);
            else
                len = RUN_MAX;
            for (int k = 0; k < len; k++) begin
                row.value = pick_value();
                row.last  = (k == len - 1) && (len < RUN_MAX || $urandom_range(1) == 1);
                send_row(row);
            end
            sent += len;
        end
    endtask

    // Compare each sorted word that leaves with the oldest one due; vary back-pressure
    always @(posedge i_clk) begin : sorted_check
        t_sorted_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (sorted_due.size() == 0) begin
                $error("unexpected sorted word %0d (last %0d)", m_tdata, m_tlast);
                failed = 1'b1;
            end else begin
                want = sorted_due.pop_front();
                if (m_tdata !== want.value) begin
                    $error("sorted_value: expected %0d, actual %0d", want.value, m_tdata);
                    failed = 1'b1;
                end
                if (m_tlast !== want.last) begin
                    $error("last_out: expected %0d, actual %0d", want.last, m_tlast);
                    failed = 1'b1;
                end
            end
        end
        m_tready <= i_rst_n && ($urandom_range(99) >= sink_idle);
    end

    initial begin
        int waited;

        // Single-word runs at both extremes and at -1: each comes back unchanged and marked last
        directed_rows[0] = '{32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF, 1'b1};
        directed_rows[1] = '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b1};
        directed_rows[2] = '{-32'sd1,        1'b1, 1'b1, -32'sd1,        1'b1};
        // Short run spanning both signs and both extremes
        directed_rows[3] = '{32'sd0,         1'b0, 1'b0, 32'sd0, 1'b0};
        directed_rows[4] = '{-32'sd3,        1'b0, 1'b0, 32'sd0, 1'b0};
        directed_rows[5] = '{32'sh7FFF_FFFF, 1'b0, 1'b0, 32'sd0, 1'b0};
        directed_rows[6] = '{32'sh8000_0000, 1'b1, 1'b0, 32'sd0, 1'b0};
        // Tied pair
        directed_rows[7] = '{32'sd7,         1'b0, 1'b0, 32'sd0, 1'b0};
        directed_rows[8] = '{32'sd7,         1'b1, 1'b0, 32'sd0, 1'b0};
        // Buffer filled with no end mark: the sixteenth word closes the run
        for (int k = 0; k < RUN_MAX; k++) begin
            directed_rows[9 + k].value  = (k % 3 == 0) ? 32'sd5 : $signed(32'h9E37_79B9 * (k + 1));
            directed_rows[9 + k].last   = 1'b0;
            directed_rows[9 + k].pinned = 1'b0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        feed_idle = 27;
        sink_idle = 47;
        cfg_write(ADDR_ORDER, 32'h0);
        cfg_check();
        foreach (directed_rows[r])
            send_row(directed_rows[r]);

        // Random runs over several order settings and idle patterns
        for (int seg = 0; seg < 6; seg++) begin
            settle();
            case (seg / 2)
                0: begin feed_idle = 27; sink_idle = 47; end
                1: begin feed_idle = 47; sink_idle = 27; end
                default: begin feed_idle = 0; sink_idle = 0; end
            endcase
            case (seg)
                0: cfg_write(ADDR_ORDER, 32'h1);
                // only bit 0 counts
                1: cfg_write(ADDR_ORDER, 32'hFFFF_FFFE);
                2: cfg_write(ADDR_ORDER, 32'hFFFF_FFFF);
                // unmapped index must leave the order alone
                3: begin
                    cfg_write(ADDR_ORDER, 32'h0);
                    cfg_write(ADDR_SPARE, 32'hFFFF_FFFF);
                end
                4: cfg_write(ADDR_ORDER, 32'h1);
                default: cfg_write(ADDR_ORDER, 32'h0);
            endcase
            cfg_check();
            random_runs(SEG_WORDS);
        end

        // Drain, then allow for the output latency
        s_tvalid <= 1'b0;
        waited = 0;
        while (sorted_due.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (sorted_due.size() != 0) begin
            $error("sorted words never produced: %0d", sorted_due.size());
            failed = 1'b1;
        end

        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ssort_pkg.sv
rtl/ssort_store.sv
rtl/ssort_ctrl.sv
rtl/selection_sort_engine_top.sv
sim/tb.sv
